>>> rtl/dsd_pkg.sv
// Shared types, constants and segment table for the signed decimal display converter.
package dsd_pkg;

   localparam int NUM_POS   = 6;
   localparam int MAG_W     = 20;
   localparam int DIGIT_W   = 4;
   localparam int PROD_W    = 2 * MAG_W;
   localparam int RECIP_SH  = 23;

   localparam logic [MAG_W-1:0] CLIP_HIGH = 20'd999999;
   localparam logic [MAG_W-1:0] CLIP_LOW  = 20'd99999;
   // floor(2^23 / 10) + 1: exact quotient by ten for every 20-bit magnitude
   localparam logic [MAG_W-1:0] RECIP_TEN = 20'd838861;

   localparam logic [6:0] SEG_MINUS = 7'h02;
   localparam logic [6:0] SEG_BLANK = 7'h00;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_BATTERY = 1'b0;

   typedef struct packed {
      logic [MAG_W-1:0]                quot;
      logic                            neg;
      logic [2:0]                      dd;
      logic [NUM_POS-1:0][DIGIT_W-1:0] digits;
      logic [NUM_POS-1:0]              shown;
   } pipe_type;

   function automatic logic [6:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
      logic [6:0] pat;
      case (digit)
         4'd0: pat = 7'h7D;
         4'd1: pat = 7'h60;
         4'd2: pat = 7'h3E;
         4'd3: pat = 7'h7A;
         4'd4: pat = 7'h63;
         4'd5: pat = 7'h5B;
         4'd6: pat = 7'h5F;
         4'd7: pat = 7'h70;
         4'd8: pat = 7'h7F;
         4'd9: pat = 7'h7B;
         default: pat = SEG_BLANK;
      endcase
      return pat;
   endfunction

endpackage

>>> rtl/signed_decimal_to_seven_segment_unit.sv
// Stages from an accepted word to its result word: clip, five divide-by-ten, encode.
// Throughput: one word per cycle; the five constant-reciprocal multiply stages set the depth.
// A stall at the result side freezes the whole pipeline; no word is lost or repeated.
// Reset (synchronous, active high) clears all valid bits and the battery mark register.
// Registers: battery_marks at byte address 0.
module signed_decimal_to_seven_segment_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [31:0]             req_value,
   input  logic [2:0]                     req_decimal_digits,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_seg_pos0,
   output logic [7:0]                     rsp_seg_pos1,
   output logic [7:0]                     rsp_seg_pos2,
   output logic [7:0]                     rsp_seg_pos3,
   output logic [7:0]                     rsp_seg_pos4,
   output logic [7:0]                     rsp_seg_pos5,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [dsd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import dsd_pkg::*;

   localparam int DIV_STAGES = NUM_POS - 1;

   logic [2:0]   battery_ff;
   logic         advance;
   logic         csr_write;
   logic         clip_valid;
   pipe_type     clip_pipe;
   logic     [DIV_STAGES:0] div_valid;
   pipe_type [DIV_STAGES:0] div_pipe;

   assign advance    = !(rsp_valid && rsp_stall);
   assign req_stall  = !advance;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_BATTERY) ? {29'd0, battery_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         battery_ff <= '0;
      end else if (csr_write && (csr_paddr[2] == CSR_IDX_BATTERY)) begin
         battery_ff <= csr_pwdata[2:0];
      end
   end

   dsd_clip u_clip (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .valid_in       (req_valid),
      .value          (req_value),
      .decimal_digits (req_decimal_digits),
      .valid_out      (clip_valid),
      .pipe_out       (clip_pipe)
   );

   assign div_valid[0] = clip_valid;
   assign div_pipe[0]  = clip_pipe;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      dsd_digit u_digit (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (div_valid[g]),
         .pipe_in   (div_pipe[g]),
         .valid_out (div_valid[g+1]),
         .pipe_out  (div_pipe[g+1])
      );
   end

   dsd_encode u_encode (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .valid_in      (div_valid[DIV_STAGES]),
      .pipe_in       (div_pipe[DIV_STAGES]),
      .battery_marks (battery_ff),
      .valid_out     (rsp_valid),
      .seg_pos0      (rsp_seg_pos0),
      .seg_pos1      (rsp_seg_pos1),
      .seg_pos2      (rsp_seg_pos2),
      .seg_pos3      (rsp_seg_pos3),
      .seg_pos4      (rsp_seg_pos4),
      .seg_pos5      (rsp_seg_pos5)
   );

endmodule

>>> rtl/dsd_clip.sv
// First stage: sign split, magnitude and saturation.
module dsd_clip (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               valid_in,
   input  logic signed [31:0] value,
   input  logic [2:0]         decimal_digits,
   output logic               valid_out,
   output dsd_pkg::pipe_type  pipe_out
);
   import dsd_pkg::*;

   logic              valid_ff;
   pipe_type          pipe_ff;
   pipe_type          pipe_in;
   logic              neg;
   logic [31:0]       mag_full;
   logic [MAG_W-1:0]  mag_clip;

   always_comb begin
      neg      = value[31];
      mag_full = neg ? (~value + 32'd1) : value;
      if (neg) begin
         mag_clip = (mag_full > {12'd0, CLIP_LOW}) ? CLIP_LOW : mag_full[MAG_W-1:0];
      end else begin
         mag_clip = (mag_full > {12'd0, CLIP_HIGH}) ? CLIP_HIGH : mag_full[MAG_W-1:0];
      end
      pipe_in        = '0;
      pipe_in.quot   = mag_clip;
      pipe_in.neg    = neg;
      pipe_in.dd     = decimal_digits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff <= pipe_in;
      end
   end

   assign valid_out = valid_ff;
   assign pipe_out  = pipe_ff;

endmodule

>>> rtl/dsd_digit.sv
// One divide-by-ten stage: peel off the low decimal digit of the running quotient.
module dsd_digit (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              valid_in,
   input  dsd_pkg::pipe_type pipe_in,
   output logic              valid_out,
   output dsd_pkg::pipe_type pipe_out
);
   import dsd_pkg::*;

   logic              valid_ff;
   pipe_type          pipe_ff;
   pipe_type          next_in;
   logic [PROD_W-1:0] prod;
   logic [MAG_W-1:0]  quot_ten;
   logic [MAG_W-1:0]  back_ten;
   logic [MAG_W-1:0]  rem_full;

   always_comb begin
      prod     = pipe_in.quot * RECIP_TEN;
      quot_ten = MAG_W'(prod[PROD_W-1:RECIP_SH]);
      back_ten = (quot_ten << 3) + (quot_ten << 1);
      rem_full = pipe_in.quot - back_ten;

      next_in        = pipe_in;
      next_in.quot   = quot_ten;
      // shift digits down; the newest goes to the top slot
      next_in.digits = {rem_full[DIGIT_W-1:0], pipe_in.digits[NUM_POS-1:1]};
      next_in.shown  = {(pipe_in.quot != '0), pipe_in.shown[NUM_POS-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff <= next_in;
      end
   end

   assign valid_out = valid_ff;
   assign pipe_out  = pipe_ff;

endmodule

>>> rtl/dsd_encode.sv
// Last stage: blanking, minus sign, segment patterns, marks and decimal point.
module dsd_encode (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              valid_in,
   input  dsd_pkg::pipe_type pipe_in,
   input  logic [2:0]        battery_marks,
   output logic              valid_out,
   output logic [7:0]        seg_pos0,
   output logic [7:0]        seg_pos1,
   output logic [7:0]        seg_pos2,
   output logic [7:0]        seg_pos3,
   output logic [7:0]        seg_pos4,
   output logic [7:0]        seg_pos5
);
   import dsd_pkg::*;

   logic                            valid_ff;
   logic [NUM_POS-1:0][7:0]         seg_ff;
   logic [NUM_POS-1:0][7:0]         seg_in;
   logic [NUM_POS-1:0][DIGIT_W-1:0] digit;
   logic [NUM_POS-1:0]              shown;
   logic [NUM_POS-1:0]              below;
   logic [NUM_POS-1:0]              mark;

   always_comb begin
      // the remaining quotient is the top digit; index i weighs 10^i
      digit = {pipe_in.quot[DIGIT_W-1:0], pipe_in.digits[NUM_POS-1:1]};
      shown = {(pipe_in.quot != '0), pipe_in.shown[NUM_POS-1:2], 1'b1};
      // below[i]: the next lower weight is lit, so a minus sign may sit at weight i
      below = {shown[NUM_POS-2:0], 1'b0};
      // bit 7 per position: battery marks on the left, decimal point on the right
      mark  = {(pipe_in.dd == 3'd1), (pipe_in.dd == 3'd2), (pipe_in.dd == 3'd3),
               battery_marks};
      for (int p = 0; p < NUM_POS; p++) begin
         seg_in[p] = '0;
         if (shown[NUM_POS-1-p]) begin
            seg_in[p][6:0] = seg_pattern(digit[NUM_POS-1-p]);
         end else if (pipe_in.neg && below[NUM_POS-1-p]) begin
            seg_in[p][6:0] = SEG_MINUS;
         end
         seg_in[p][7] = mark[p];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         seg_ff <= seg_in;
      end
   end

   assign valid_out = valid_ff;
   assign seg_pos0  = seg_ff[0];
   assign seg_pos1  = seg_ff[1];
   assign seg_pos2  = seg_ff[2];
   assign seg_pos3  = seg_ff[3];
   assign seg_pos4  = seg_ff[4];
   assign seg_pos5  = seg_ff[5];

endmodule

>>> dv/tb_signed_decimal_to_seven_segment_unit.sv
// Testbench for the signed decimal to seven-segment display converter.
`timescale 1ns / 1ps

module tb_signed_decimal_to_seven_segment_unit;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 8;
   localparam int IDLE_LIMIT    = 5000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 267;
   localparam int REPORT_MAX    = 10;

   localparam logic [31:0] POS_CLIP = 32'd999999;
   localparam logic [31:0] NEG_CLIP = 32'd99999;
   localparam logic [7:0]  MINUS_SEG = 8'h02;

   localparam logic [dsd_pkg::CSR_ADDR_W-1:0] ADDR_BATTERY = 3'd0;
   localparam logic [dsd_pkg::CSR_ADDR_W-1:0] ADDR_UNUSED  = 3'd4;

   localparam logic [6:0] DIGIT_SEG [10] = '{
      7'h7D, 7'h60, 7'h3E, 7'h7A, 7'h63, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B
   };

   localparam int BOUNDARY_VALUES [12] = '{
      0, 1, -1, 9, 10, 99999, 100000, -99999, -100000, 999999, 1000000,
      int'(32'h8000_0000)
   };

   typedef struct {
      logic signed [31:0] value;
      logic [2:0]         dd;
   } number_word_type;

   typedef struct {
      number_word_type  src;
      logic [5:0][7:0]  segs;
   } display_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [31:0]   req_value = '0;
   logic [2:0]           req_decimal_digits = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_seg_pos0, rsp_seg_pos1, rsp_seg_pos2;
   logic [7:0]           rsp_seg_pos3, rsp_seg_pos4, rsp_seg_pos5;
   logic                 csr_psel = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite = 1'b0;
   logic [dsd_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]          csr_pwdata = '0;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   number_word_type  pending_numbers_q [$];
   display_word_type expected_displays_q [$];
   logic [2:0]       battery_shadow = 3'b000;

   bit pressure_phase = 1'b0;
   bit quiet_phase = 1'b0;
   int mismatch_count = 0;
   int numbers_sent = 0;
   int displays_checked = 0;
   int settings_used = 0;

   signed_decimal_to_seven_segment_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_value          (req_value),
      .req_decimal_digits (req_decimal_digits),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_seg_pos0       (rsp_seg_pos0),
      .rsp_seg_pos1       (rsp_seg_pos1),
      .rsp_seg_pos2       (rsp_seg_pos2),
      .rsp_seg_pos3       (rsp_seg_pos3),
      .rsp_seg_pos4       (rsp_seg_pos4),
      .rsp_seg_pos5       (rsp_seg_pos5),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Expected six-position display for one number under the given battery marks.
   function automatic logic [5:0][7:0] encode_display(input logic signed [31:0] value,
                                                      input logic [2:0] dd,
                                                      input logic [2:0] marks);
      logic [5:0][7:0] seg;
      logic [31:0]     mag;
      logic            neg;
      int              pos;
      neg = value[31];
      if (neg) begin
         mag = ~value + 32'd1;
         if (mag > NEG_CLIP) mag = NEG_CLIP;
      end else begin
         mag = value;
         if (mag > POS_CLIP) mag = POS_CLIP;
      end
      seg = '0;
      pos = 5;
      // at least one digit, so zero still shows a single 0
      do begin
         seg[pos] = {1'b0, DIGIT_SEG[mag % 10]};
         mag = mag / 10;
         pos--;
      end while (mag != 0 && pos >= 0);
      if (neg && pos >= 0) seg[pos] = MINUS_SEG;
      for (int k = 0; k < 3; k++) begin
         if (marks[k]) seg[k][7] = 1'b1;
      end
      if (dd >= 3'd1 && dd <= 3'd3) seg[6 - int'(dd)][7] = 1'b1;
      return seg;
   endfunction

   // Mostly short gaps, a few long ones.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [31:0] random_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return $urandom;
      if (r < 65) return int'($urandom_range(0, 1220000)) - 120000;
      if (r < 80) return int'($urandom_range(0, 200)) - 100;
      return BOUNDARY_VALUES[$urandom_range(0, 11)] + int'($urandom_range(0, 4)) - 2;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) $display("[%0t] MISMATCH %s", $realtime, msg);
   endtask

   task automatic queue_number(input logic signed [31:0] value, input logic [2:0] dd);
      number_word_type w;
      w.value = value;
      w.dd = dd;
      pending_numbers_q.push_back(w);
   endtask

   // Sample at the falling edge so the driver's queue and valid are seen settled.
   task automatic wait_drained();
      while (pending_numbers_q.size() != 0 || req_valid || expected_displays_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [dsd_pkg::CSR_ADDR_W-1:0] addr,
                             input logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (write && addr == ADDR_BATTERY) battery_shadow = data[2:0];
      if (!write && addr == ADDR_BATTERY && csr_prdata !== {29'd0, battery_shadow})
         note_mismatch($sformatf("battery_marks read exp %h act %h",
                                 {29'd0, battery_shadow}, csr_prdata));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Driver: hold a stalled word, otherwise advance to the next pending word after a gap.
   always @(posedge clock) begin : drive_proc
      number_word_type  w;
      display_word_type e;
      int               send_gap;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            e.src.value = req_value;
            e.src.dd = req_decimal_digits;
            e.segs = encode_display(req_value, req_decimal_digits, battery_shadow);
            expected_displays_q.push_back(e);
            numbers_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_numbers_q.size() > 0) begin
               w = pending_numbers_q.pop_front();
               req_valid <= 1'b1;
               req_value <= w.value;
               req_decimal_digits <= w.dd;
               send_gap = quiet_phase ? 0 : gap_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result word against the oldest expectation, then pick the stall.
   always @(posedge clock) begin : collect_proc
      logic [5:0][7:0]  got;
      display_word_type want;
      int               hold_left;
      int               stall_left;
      bit               hold_done;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         stall_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_seg_pos5, rsp_seg_pos4, rsp_seg_pos3,
                   rsp_seg_pos2, rsp_seg_pos1, rsp_seg_pos0};
            if (expected_displays_q.size() == 0) begin
               note_mismatch($sformatf("unexpected result word %h", got));
            end else begin
               want = expected_displays_q.pop_front();
               displays_checked++;
               if (got !== want.segs) begin
                  for (int k = 0; k < 6; k++) begin
                     if (got[k] !== want.segs[k])
                        note_mismatch($sformatf("value %0d dd %0d seg_pos%0d exp %h act %h",
                                                want.src.value, want.src.dd, k,
                                                want.segs[k], got[k]));
                  end
               end
            end
         end
         if (pressure_phase && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (quiet_phase) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 4) == 0) stall_left = gap_len();
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin : watchdog_proc
      int idle_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus_proc
      logic [2:0] mark_plan [RANDOM_PHASES];
      mark_plan = '{3'b111, 3'b101, 3'b010, 3'b000, 3'b000, 3'b111};
      mark_plan[4] = 3'($urandom);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset value first, then a write of zero with junk in the unused bits.
      csr_access(1'b0, ADDR_BATTERY, '0);
      csr_access(1'b1, ADDR_BATTERY, 32'hFFFF_FFF8);
      settings_used++;
      queue_number(0, 3'd0);
      queue_number(1, 3'd1);
      queue_number(-1, 3'd2);
      queue_number(9, 3'd3);
      queue_number(10, 3'd4);
      queue_number(99999, 3'd5);
      queue_number(100000, 3'd6);
      queue_number(-99999, 3'd7);
      queue_number(-100000, 3'd1);
      queue_number(999999, 3'd2);
      queue_number(1000000, 3'd3);
      queue_number(32'sh7FFF_FFFF, 3'd0);
      queue_number(32'sh8000_0000, 3'd3);
      queue_number(123456, 3'd1);
      queue_number(-12345, 3'd2);
      queue_number(-5, 3'd3);
      queue_number(-9, 3'd0);
      queue_number(888888, 3'd7);
      queue_number(-88888, 3'd1);
      queue_number(32'sh5555_5555, 3'd2);
      queue_number(32'shAAAA_AAAA, 3'd5);
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         csr_access(1'b1, ADDR_BATTERY,
                    {29'($urandom_range(0, 32'h1FFF_FFFF)), mark_plan[ph]});
         if (ph == 3) csr_access(1'b1, ADDR_UNUSED, $urandom);
         csr_access(1'b0, ADDR_BATTERY, '0);
         settings_used++;
         pressure_phase = (ph == 1);
         quiet_phase = (ph == 4);
         for (int i = 0; i < PHASE_ITEMS; i++) queue_number(random_value(), 3'($urandom));
         // pause the sender until every result of this phase is back
         wait_drained();
         pressure_phase = 1'b0;
         quiet_phase = 1'b0;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_displays_q.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", expected_displays_q.size()));

      $display("Covered %0d numbers and %0d displays over %0d battery-mark settings,",
               numbers_sent, displays_checked, settings_used);
      $display("with clipping, zero, all point positions, a long output hold; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
